/* rtl/bgd_pkg.sv */
// shared types and constants for the button gesture detector
// no dependencies; imported by every module of the block
package bgd_pkg;

    localparam int unsigned TicksW = 16;
    localparam int unsigned PinW   = 5;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 8;

    localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CLICK_WINDOW = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WATCHED_PIN  = 2'd2;

    localparam logic [TicksW-1:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic [TicksW-1:0] CLICK_WINDOW_RESET = 16'd300;
    localparam logic [PinW-1:0]   WATCHED_PIN_RESET  = 5'd0;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_PRESS   = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRESS1 = 3'd1,
        PH_WAIT   = 3'd2,
        PH_PRESS2 = 3'd3,
        PH_HELD   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [TicksW-1:0] long_press_ticks;
        logic [TicksW-1:0] click_window_ticks;
        logic [PinW-1:0]   watched_pin;
    } t_cfg;

endpackage

/* rtl/button_gesture_detector.sv */
// top level of the button gesture detector: stream ports, input and result registers
// depends on bgd_pkg, bgd_cfg_regs, bgd_fsm
//
// One item (tick, press or release) is accepted per clock cycle while the output is not
// stalled, and gives exactly one result item carrying the gesture event. An accepted
// item passes the input register and then the result register, which presents it until
// it is taken. An item is captured in the input register, the phase machine and its
// 16-bit countdown are updated by one short step of logic, and the event lands in the
// result register. While a result waits, the input register can still take one more
// item and then the input stalls until the result is taken. Limit registers take
// effect at the next load of the countdown; a limit of zero behaves as one tick.
module button_gesture_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // fields from bit 0: command[1:0], pin_number[6:2], zero fill
    input  logic [bgd_pkg::InDataW-1:0]  s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // fields from bit 0: gesture_event[1:0], zero fill
    output logic [bgd_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic                         i_cfg_we,
    input  logic [bgd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bgd_pkg::CfgDataW-1:0] i_cfg_data
);
    import bgd_pkg::*;

    t_cfg             w_cfg;
    logic             r_in_valid;
    t_cmd             r_cmd;
    logic [PinW-1:0]  r_pin;
    logic             r_out_valid;
    t_event           r_event;
    t_event           w_event;
    logic             w_out_load;
    logic             w_step;

    bgd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bgd_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cmd   (r_cmd),
        .i_pin   (r_pin),
        .i_cfg   (w_cfg),
        .o_event (w_event)
    );

    // result register can take a new item when empty or being drained
    assign w_out_load    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_load;
    assign s_axis_tready = !r_in_valid || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= t_cmd'(s_axis_tdata[1:0]);
            r_pin <= s_axis_tdata[PinW+1:2];
        end
        if (w_step) begin
            r_event <= w_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OutDataW-2)'(0), r_event};

endmodule

/* rtl/bgd_cfg_regs.sv */
// configuration registers of the gesture detector
// depends on bgd_pkg
module bgd_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bgd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bgd_pkg::CfgDataW-1:0] i_cfg_data,
    output bgd_pkg::t_cfg                o_cfg
);
    import bgd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks   <= LONG_PRESS_RESET;
            r_cfg.click_window_ticks <= CLICK_WINDOW_RESET;
            r_cfg.watched_pin        <= WATCHED_PIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LONG_PRESS:   r_cfg.long_press_ticks   <= i_cfg_data[TicksW-1:0];
                CFG_CLICK_WINDOW: r_cfg.click_window_ticks <= i_cfg_data[TicksW-1:0];
                CFG_WATCHED_PIN:  r_cfg.watched_pin        <= i_cfg_data[PinW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/bgd_fsm.sv */
// gesture phase machine and countdown; updates once per processed item
// depends on bgd_pkg
module bgd_fsm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  bgd_pkg::t_cmd             i_cmd,
    input  logic [bgd_pkg::PinW-1:0]  i_pin,
    input  bgd_pkg::t_cfg             i_cfg,
    output bgd_pkg::t_event           o_event
);
    import bgd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TicksW-1:0] r_ticks, n_ticks;
    logic [TicksW-1:0] w_tick_dec;
    logic [TicksW-1:0] w_long_load, w_window_load;
    logic              w_pin_hit;
    t_event            w_event;

    // a limit of zero loads as one
    assign w_long_load   = (i_cfg.long_press_ticks == '0)
                         ? TicksW'(1) : i_cfg.long_press_ticks;
    assign w_window_load = (i_cfg.click_window_ticks == '0)
                         ? TicksW'(1) : i_cfg.click_window_ticks;
    assign w_tick_dec    = r_ticks - TicksW'(1);
    assign w_pin_hit     = (i_pin == i_cfg.watched_pin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        w_event = EV_NONE;
        unique case (i_cmd)
            CMD_TICK: begin
                if (r_ticks != '0) begin
                    n_ticks = w_tick_dec;
                    if (w_tick_dec == '0) begin
                        // countdown expired
                        unique case (r_phase)
                            PH_PRESS1, PH_PRESS2: begin
                                n_phase = PH_HELD;
                                w_event = EV_LONG;
                            end
                            PH_WAIT: begin
                                n_phase = PH_IDLE;
                                w_event = EV_SINGLE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_PRESS: begin
                if (w_pin_hit) begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            n_phase = PH_PRESS1;
                            n_ticks = w_long_load;
                        end
                        PH_WAIT: begin
                            n_phase = PH_PRESS2;
                            n_ticks = w_long_load;
                        end
                        default: ;
                    endcase
                end
            end
            CMD_RELEASE: begin
                if (w_pin_hit) begin
                    unique case (r_phase)
                        PH_PRESS1: begin
                            n_phase = PH_WAIT;
                            n_ticks = w_window_load;
                        end
                        PH_PRESS2: begin
                            n_phase = PH_IDLE;
                            n_ticks = '0;
                            w_event = EV_DOUBLE;
                        end
                        PH_HELD: begin
                            n_phase = PH_IDLE;
                            n_ticks = '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_event = w_event;

    // the countdown runs exactly while a press or the click window is open
    a_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_HELD) |-> (r_ticks == '0))
        else $error("countdown running in idle or held phase");

    a_active_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRESS1 || r_phase == PH_PRESS2 || r_phase == PH_WAIT)
        |-> (r_ticks != '0))
        else $error("countdown stopped while a gesture is open");

    a_long_to_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_event == EV_LONG) |=> (r_phase == PH_HELD))
        else $error("long press reported without entering held phase");

    a_double_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_event == EV_DOUBLE || o_event == EV_SINGLE))
        |=> (r_phase == PH_IDLE && r_ticks == '0))
        else $error("click reported without returning to idle");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for button_gesture_detector: directed gestures, then random
// press/release/tick sequences under several register settings; depends on bgd_pkg
module tb_top;
    import bgd_pkg::*;

    localparam logic [1:0]         CMD_UNUSED    = 2'd3;
    localparam logic [CfgIdxW-1:0] CFG_NO_REG    = 2'd3;
    localparam int unsigned        QUIET_LIMIT   = 2000;
    localparam int unsigned        DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [PinW-1:0] pin;
    } t_button_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    // fields from bit 0: command[1:0], pin_number[6:2], zero fill
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // fields from bit 0: gesture_event[1:0], zero fill
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    button_gesture_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and its copy of the registers
    t_phase            phase_now    = PH_IDLE;
    logic [TicksW-1:0] countdown    = '0;
    logic [TicksW-1:0] long_limit   = LONG_PRESS_RESET;
    logic [TicksW-1:0] window_limit = CLICK_WINDOW_RESET;
    logic [PinW-1:0]   watch_pin    = WATCHED_PIN_RESET;

    t_button_item button_items_q[$];
    t_event       expected_events_q[$];
    t_button_item offered;

    int unsigned sender_gap_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int          results_owed = 0;
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned settings_used = 0;
    int unsigned n_single = 0, n_double = 0, n_long = 0;

    function automatic t_event predict_gesture(logic [1:0] cmd, logic [PinW-1:0] pin);
        t_event ev;
        ev = EV_NONE;
        if (cmd == CMD_TICK) begin
            if (countdown != 0) begin
                countdown = countdown - 1'b1;
                if (countdown == 0) begin
                    if (phase_now == PH_PRESS1 || phase_now == PH_PRESS2) begin
                        phase_now = PH_HELD;
                        ev = EV_LONG;
                    end else if (phase_now == PH_WAIT) begin
                        phase_now = PH_IDLE;
                        ev = EV_SINGLE;
                    end
                end
            end
        end else if ((cmd == CMD_PRESS || cmd == CMD_RELEASE) && pin == watch_pin) begin
            if (cmd == CMD_PRESS) begin
                if (phase_now == PH_IDLE || phase_now == PH_WAIT) begin
                    if (phase_now == PH_IDLE)
                        phase_now = PH_PRESS1;
                    else
                        phase_now = PH_PRESS2;
                    // a zero limit still expires on the next tick
                    countdown = (long_limit == 0) ? TicksW'(1) : long_limit;
                end
            end else begin
                case (phase_now)
                    PH_PRESS1: begin
                        phase_now = PH_WAIT;
                        countdown = (window_limit == 0) ? TicksW'(1) : window_limit;
                    end
                    PH_PRESS2: begin
                        phase_now = PH_IDLE;
                        countdown = '0;
                        ev = EV_DOUBLE;
                    end
                    PH_HELD: begin
                        phase_now = PH_IDLE;
                        countdown = '0;
                    end
                    default: ;
                endcase
            end
        end
        return ev;
    endfunction

    // sender: one item offered at a time, held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_events_q.push_back(predict_gesture(offered.cmd, offered.pin));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (button_items_q.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    offered = button_items_q.pop_front();
                    s_axis_tdata <= InDataW'({offered.pin, offered.cmd});
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result item against the oldest prediction
    always @(posedge i_clk) begin
        t_event want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_events_q.pop_front();
                    results_owed--;
                    if (m_axis_tdata !== OutDataW'(want)) begin
                        mismatches++;
                        $display("%0t: gesture event mismatch, expected %0h (%s), actual %0h",
                                 $time, OutDataW'(want), want.name(), m_axis_tdata);
                    end
                    case (want)
                        EV_SINGLE: n_single++;
                        EV_DOUBLE: n_double++;
                        EV_LONG:   n_long++;
                        default: ;
                    endcase
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("button_gesture_detector verification failed");
        $finish;
    end

    task automatic add_item(input logic [1:0] cmd, input logic [PinW-1:0] pin);
        t_button_item it;
        it.cmd = cmd;
        it.pin = pin;
        button_items_q.push_back(it);
        results_owed++;
        items_queued++;
    endtask

    task automatic add_ticks(input int unsigned n);
        repeat (n) add_item(CMD_TICK, PinW'($urandom_range(31)));
    endtask

    // edge on the watched pin, sometimes preceded by a stray edge from another pin
    task automatic add_watched(input logic [1:0] cmd);
        if ($urandom_range(7) == 0)
            add_item(2'($urandom_range(1, 2)), watch_pin ^ PinW'($urandom_range(1, 31)));
        add_item(cmd, watch_pin);
    endtask

    task automatic push_gesture();
        int unsigned kind, lp, cw;
        lp = (long_limit == 0) ? 1 : long_limit;
        cw = (window_limit == 0) ? 1 : window_limit;
        if (lp > 24) lp = 24;
        if (cw > 24) cw = 24;
        kind = $urandom_range(9);
        if (kind <= 2) begin
            add_watched(CMD_PRESS);
            add_ticks($urandom_range(lp - 1));
            add_watched(CMD_RELEASE);
            add_ticks($urandom_range(cw + 1));
        end else if (kind <= 5) begin
            add_watched(CMD_PRESS);
            add_ticks($urandom_range(lp - 1));
            add_watched(CMD_RELEASE);
            add_ticks($urandom_range(cw - 1));
            add_watched(CMD_PRESS);
            add_ticks($urandom_range(lp + 1));
            add_watched(CMD_RELEASE);
            add_ticks($urandom_range(2));
        end else if (kind <= 7) begin
            add_watched(CMD_PRESS);
            add_ticks($urandom_range(lp + 3, lp - 1));
            if ($urandom_range(1) != 0)
                add_watched(CMD_PRESS);
            add_watched(CMD_RELEASE);
            add_ticks($urandom_range(2));
        end else begin
            repeat ($urandom_range(6, 1))
                add_item(2'($urandom_range(3)), PinW'($urandom_range(31)));
        end
    endtask

    task automatic wait_drained();
        while (results_owed != 0)
            @(posedge i_clk);
    endtask

    // the register takes the value at the next edge, before any item can be accepted
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LONG_PRESS:   long_limit = val;
            CFG_CLICK_WINDOW: window_limit = val;
            CFG_WATCHED_PIN:  watch_pin = val[PinW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input int unsigned lp, input int unsigned cw,
                              input int unsigned pin_sel);
        wait_drained();
        write_reg(CFG_LONG_PRESS, CfgDataW'(lp));
        write_reg(CFG_CLICK_WINDOW, CfgDataW'(cw));
        write_reg(CFG_WATCHED_PIN, CfgDataW'(pin_sel));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int unsigned lp, input int unsigned cw,
                             input int unsigned pin_sel, input int unsigned n_items);
        int unsigned first;
        set_limits(lp, cw, pin_sel);
        first = items_queued;
        while (items_queued - first < n_items / 2)
            push_gesture();
        // sender holds off until the block has answered everything
        wait_drained();
        while (items_queued - first < n_items)
            push_gesture();
    endtask

    initial begin
        sender_gap_pct = 13;
        receiver_stall_pct = 54;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits and pin 0: double click
        add_item(CMD_PRESS, 5'd0);
        add_item(CMD_RELEASE, 5'd0);
        add_item(CMD_PRESS, 5'd0);
        add_item(CMD_RELEASE, 5'd0);

        set_limits(2, 2, 31);
        write_reg(CFG_NO_REG, 16'hFFFF);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        add_item(CMD_TICK, 5'd31);
        add_item(CMD_UNUSED, 5'd31);
        add_item(CMD_PRESS, 5'd0);
        add_item(CMD_RELEASE, 5'd31);
        add_item(CMD_PRESS, 5'd31);
        add_item(CMD_PRESS, 5'd31);
        add_ticks(3);
        add_item(CMD_RELEASE, 5'd31);
        add_item(CMD_PRESS, 5'd31);
        add_item(CMD_RELEASE, 5'd31);
        add_item(CMD_RELEASE, 5'd31);
        add_ticks(2);
        add_item(CMD_PRESS, 5'd31);
        add_item(CMD_RELEASE, 5'd31);
        add_item(CMD_PRESS, 5'd31);
        add_ticks(2);
        add_item(CMD_RELEASE, 5'd31);

        // limits of zero behave as one tick
        set_limits(0, 0, 31);
        add_item(CMD_PRESS, 5'd31);
        add_ticks(1);
        add_item(CMD_RELEASE, 5'd31);
        add_item(CMD_PRESS, 5'd31);
        add_item(CMD_RELEASE, 5'd31);
        add_ticks(1);

        run_phase(3, 2, 5, 190);
        run_phase(1, 1, 31, 190);
        run_phase(7, 4, 0, 190);

        wait_drained();
        sender_gap_pct = 54;
        receiver_stall_pct = 13;
        run_phase(0, 0, 17, 190);
        run_phase(65535, 65535, 10, 60);
        run_phase(5, 9, 21, 200);

        wait_drained();
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        run_phase(2, 12, 31, 230);
        run_phase(10, 3, 1, 230);
        run_phase(4, 4, 14, 230);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("ran %0d items under %0d register settings", items_accepted, settings_used);
        $display("events seen: %0d single, %0d double, %0d long press; %0d mismatches",
                 n_single, n_double, n_long, mismatches);
        if (mismatches == 0 && expected_events_q.size() == 0)
            $display("button_gesture_detector verification clean");
        else
            $display("button_gesture_detector verification failed");
        $finish;
    end

endmodule

/* button_gesture_detector.f */
rtl/bgd_pkg.sv
rtl/bgd_cfg_regs.sv
rtl/bgd_fsm.sv
rtl/button_gesture_detector.sv
tb/tb_top.sv
